// ===== rtl/core/ppmcr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmcr_pkg: shared codes for the page-packed canvas raster core
// Operation codes, draw mode codes, register indexes and the fixed field
// widths of the input and result beats.
// ----------------------------------------------------------------------------
package ppmcr_pkg;

  // Field widths fixed by the interface.
  localparam int OP_W    = 2;
  localparam int POS_W   = 10;
  localparam int RECT_W  = 9;
  localparam int COLOR_W = 16;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Signed width for the clipping arithmetic: holds pos + size + offset.
  localparam int CLIP_W = 13;

  typedef logic [OP_W-1:0]       op_t;
  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [COLOR_W-1:0]    color_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [RECT_W-1:0]     rect_t;

  // Operations.
  localparam op_t OP_FILL  = 2'd0;
  localparam op_t OP_CLEAR = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  // Draw modes.
  localparam mode_t MODE_CLEAR  = 2'd0;
  localparam mode_t MODE_SET    = 2'd1;
  localparam mode_t MODE_INVERT = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t REG_DRAW_MODE   = 2'd0;
  localparam cfg_idx_t REG_FULL_SCREEN = 2'd1;
  localparam cfg_idx_t REG_FG_COLOR    = 2'd2;
  localparam cfg_idx_t REG_BG_COLOR    = 2'd3;

  // Reset values.
  localparam color_t FG_RESET = 16'hFFFF;
  localparam color_t BG_RESET = 16'h0000;

endpackage

// ===== rtl/core/page_packed_mono_canvas_raster_core.sv =====
// ----------------------------------------------------------------------------
// page_packed_mono_canvas_raster_core: 1 bpp page-packed canvas engine
// Rectangle fill with set, clear or invert, canvas clear and pixel read.
// ----------------------------------------------------------------------------
// The canvas lives in a RAM of SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes,
// one byte per column per page of eight rows. After reset, and after every
// clear operation, the core sweeps the whole RAM writing one byte per cycle
// and accepts no beat meanwhile; configuration writes are taken at any time.
// A fill first clips the rectangle (setup state) and finds the base address
// of the first page (base state), then performs one byte read-modify-write
// per cycle over the clipped columns times the pages touched, plus a drain
// step to retire the last write, with the RAM's single read port and single
// write port setting the pace. An empty or fully clipped fill returns to idle
// from the setup state. A pixel read passes through the setup, base, read
// request and result states, or from setup to result when the pixel lies off
// the canvas, and waits in the result state while a previous result beat is
// still stalled. The core takes one input beat at a time.
// ----------------------------------------------------------------------------
module page_packed_mono_canvas_raster_core #(
  parameter int SCREEN_WIDTH    = 128,
  parameter int SCREEN_HEIGHT   = 160,
  parameter int TOP_BAR_ROWS    = 20,
  parameter int BOTTOM_BAR_ROWS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration port.
  input  logic                cfg_we,
  input  ppmcr_pkg::cfg_idx_t cfg_index,
  input  ppmcr_pkg::cfg_data_t cfg_data,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  ppmcr_pkg::op_t      in_op,
  input  ppmcr_pkg::pos_t     in_pos_x,
  input  ppmcr_pkg::pos_t     in_pos_y,
  input  ppmcr_pkg::rect_t    in_rect_width,
  input  ppmcr_pkg::rect_t    in_rect_height,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output ppmcr_pkg::color_t   out_pixel_color,
  output logic                out_pixel_on
);

  import ppmcr_pkg::*;

  // Geometry derived from the parameters.
  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(SCREEN_WIDTH);
  localparam int RW = $clog2(SCREEN_HEIGHT);
  localparam int PW = (RW > 3) ? RW - 3 : 1;

  localparam logic [AW-1:0] WIDTH_A   = AW'(SCREEN_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  localparam logic signed [CLIP_W-1:0] ZERO_S = '0;
  localparam logic signed [CLIP_W-1:0] ONE_S  = CLIP_W'(1);
  localparam logic signed [CLIP_W-1:0] W_S    = CLIP_W'(SCREEN_WIDTH);
  localparam logic signed [CLIP_W-1:0] H_S    = CLIP_W'(SCREEN_HEIGHT);
  localparam logic signed [CLIP_W-1:0] TOP_S  = CLIP_W'(TOP_BAR_ROWS);
  localparam logic signed [CLIP_W-1:0] BOT_S  = CLIP_W'(BOTTOM_BAR_ROWS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_BASE  = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_RDREQ = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;
  localparam logic [2:0] S_CLR   = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Configuration registers.
  mode_t  draw_mode_r;
  logic   full_screen_r;
  color_t fg_color_r;
  color_t bg_color_r;

  // Captured input beat.
  op_t   op_r;
  pos_t  px_r;
  pos_t  py_r;
  rect_t w_r;
  rect_t h_r;

  // Walk state.
  logic [CW-1:0] col0_r, col1_r, col_r;
  logic [RW-1:0] row0_r, row1_r;
  logic [PW-1:0] page_r;
  logic [AW-1:0] page_base_r;
  logic [2:0]    bit_r;
  logic          inside_r;
  logic [AW-1:0] clr_addr_r;

  // Pending read-modify-write.
  logic          pend_r;
  logic [AW-1:0] pend_addr_r;
  logic [7:0]    pend_mask_r;

  // Result register.
  logic   out_valid_r;
  color_t out_color_r;
  logic   out_on_r;

  // RAM ports.
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [7:0]    ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;

  logic in_accept;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Clipping of the captured rectangle.
  logic signed [CLIP_W-1:0] x0_s, x1_s, y0_s, y1_s, max_y_s;
  logic signed [CLIP_W-1:0] x0_c, x1_c, y0_c, y1_c;
  logic                     fill_empty;
  logic                     read_inside;
  logic [RW-1:0]            row0_c, row1_c, read_row;

  always_comb begin
    x0_s    = CLIP_W'(px_r);
    x1_s    = x0_s + $signed({{(CLIP_W-RECT_W){1'b0}}, w_r}) - ONE_S;
    y0_s    = CLIP_W'(py_r) + (full_screen_r ? ZERO_S : TOP_S);
    y1_s    = y0_s + $signed({{(CLIP_W-RECT_W){1'b0}}, h_r}) - ONE_S;
    max_y_s = full_screen_r ? H_S : (H_S - BOT_S);
    x0_c    = (x0_s < ZERO_S) ? ZERO_S : x0_s;
    y0_c    = (y0_s < ZERO_S) ? ZERO_S : y0_s;
    x1_c    = (x1_s >= W_S) ? (W_S - ONE_S) : x1_s;
    y1_c    = (y1_s >= max_y_s) ? (max_y_s - ONE_S) : y1_s;
    fill_empty = (w_r == '0) || (h_r == '0) || (x0_c > x1_c) || (y0_c > y1_c);
    row0_c  = y0_c[RW-1:0];
    row1_c  = y1_c[RW-1:0];
    read_inside = (CLIP_W'(px_r) >= ZERO_S) && (CLIP_W'(px_r) < W_S) &&
                  (CLIP_W'(py_r) >= ZERO_S) && (CLIP_W'(py_r) < H_S);
    read_row = py_r[RW-1:0];
  end

  // Address of the byte under the walk, and the row mask of the current page.
  logic [AW-1:0] fill_addr;
  logic [PW-1:0] page_first, page_last;
  logic [2:0]    mask_lo, mask_hi;
  logic [7:0]    page_mask;

  always_comb begin
    fill_addr  = page_base_r + AW'(col_r);
    page_first = PW'(row0_r >> 3);
    page_last  = PW'(row1_r >> 3);
    mask_lo    = (page_r == page_first) ? row0_r[2:0] : 3'd0;
    mask_hi    = (page_r == page_last) ? row1_r[2:0] : 3'd7;
    page_mask  = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));
  end

  // Modified byte for the pending write.
  logic [7:0] fill_byte;
  always_comb begin
    case (draw_mode_r)
      MODE_SET:    fill_byte = ram_rd_data | pend_mask_r;
      MODE_INVERT: fill_byte = ram_rd_data ^ pend_mask_r;
      default:     fill_byte = ram_rd_data & ~pend_mask_r;
    endcase
  end

  // RAM port control.
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = fill_addr;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pend_addr_r;
    ram_wr_data = fill_byte;
    if (state_r == S_FILL || state_r == S_RDREQ) begin
      ram_rd_en = 1'b1;
    end
    if (state_r == S_CLR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = '0;
    end else if (pend_r) begin
      ram_wr_en = 1'b1;
    end
  end

  logic read_bit;
  assign read_bit = inside_r && ram_rd_data[bit_r];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        case (op_r)
          OP_FILL:  state_nxt = fill_empty ? S_IDLE : S_BASE;
          OP_CLEAR: state_nxt = S_CLR;
          OP_READ:  state_nxt = read_inside ? S_BASE : S_RES;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_BASE: begin
        state_nxt = (op_r == OP_FILL) ? S_FILL : S_RDREQ;
      end
      S_FILL: begin
        if (col_r == col1_r && page_r == page_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_IDLE;
      S_RDREQ: state_nxt = S_RES;
      S_RES: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      S_CLR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_addr_r    <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      draw_mode_r   <= MODE_SET;
      full_screen_r <= 1'b0;
      fg_color_r    <= FG_RESET;
      bg_color_r    <= BG_RESET;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == S_FILL);

      if (state_r == S_CLR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end else begin
        clr_addr_r <= '0;
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_RES && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_DRAW_MODE:   draw_mode_r   <= cfg_data[MODE_W-1:0];
          REG_FULL_SCREEN: full_screen_r <= cfg_data[0];
          REG_FG_COLOR:    fg_color_r    <= cfg_data[COLOR_W-1:0];
          REG_BG_COLOR:    bg_color_r    <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= in_op;
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      w_r  <= in_rect_width;
      h_r  <= in_rect_height;
    end

    // Clip or locate the pixel.
    if (state_r == S_SETUP) begin
      inside_r <= read_inside;
      if (op_r == OP_FILL) begin
        col0_r <= x0_c[CW-1:0];
        col1_r <= x1_c[CW-1:0];
        col_r  <= x0_c[CW-1:0];
        row0_r <= row0_c;
        row1_r <= row1_c;
        page_r <= PW'(row0_c >> 3);
      end else begin
        col_r  <= px_r[CW-1:0];
        page_r <= PW'(read_row >> 3);
        bit_r  <= py_r[2:0];
      end
    end

    // First page base address.
    if (state_r == S_BASE) begin
      page_base_r <= AW'(page_r) * WIDTH_A;
    end

    // Column-then-page walk, one byte per cycle.
    if (state_r == S_FILL) begin
      pend_addr_r <= fill_addr;
      pend_mask_r <= page_mask;
      if (col_r == col1_r) begin
        col_r <= col0_r;
        if (page_r != page_last) begin
          page_r      <= page_r + PW'(1);
          page_base_r <= page_base_r + WIDTH_A;
        end
      end else begin
        col_r <= col_r + CW'(1);
      end
    end

    // Result beat.
    if (state_r == S_RES && (!out_valid_r || !out_stall)) begin
      out_on_r    <= read_bit;
      out_color_r <= read_bit ? fg_color_r : bg_color_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;
  assign out_pixel_on    = out_on_r;

  ppmcr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // A pending write always belongs to the byte read in the previous cycle.
  a_pend_follows_fill: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r) == S_FILL)
    else $error("pending write without a preceding fill read");

  // The walk never reads the byte that is being written back.
  a_no_rmw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && pend_r) |-> ram_rd_addr != pend_addr_r)
    else $error("fill read collides with pending write");

  // The walk stays inside the store.
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> fill_addr <= LAST_ADDR)
    else $error("fill address beyond the store");

  // A result beat is raised only by the read result step.
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RES)
    else $error("result beat raised outside a pixel read");

endmodule

// ===== rtl/core/ppmcr_ram.sv =====
// ----------------------------------------------------------------------------
// ppmcr_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is requested.
// ----------------------------------------------------------------------------
module ppmcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2560
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
